### rtl/mbt_pkg.sv
package mbt_pkg;

	localparam int ACT_W = 2;

	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;
	localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd3;

	localparam int IN_KEY_W = 32;
	localparam int CNT_W    = 5;
	localparam int OUT_W    = 16;

	typedef struct packed {
		logic load;
		logic issue;
		logic read_last;
		logic commit;
	} mbt_cmd_t;

	typedef struct packed {
		logic issued_all;
		logic cmp_pend;
		logic need_last;
		logic out_free;
	} mbt_stat_t;

endpackage

### rtl/mbt_ctrl.sv
module mbt_ctrl
	import mbt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  mbt_stat_t stat,
	output mbt_cmd_t  cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				if (!stat.issued_all) begin
					cmd.issue = 1'b1;
				end else if (!stat.cmp_pend) begin
					// fetch the last entry to fill the hole left by a remove
					cmd.read_last = stat.need_last;
					state_d       = S_FIN;
				end
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> stat.out_free)
		else $error("commit while output register is occupied");

	a_load_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !cmd.issue && !cmd.commit && !cmd.read_last)
		else $error("load overlaps other commands");

endmodule

### rtl/mbt_dp.sv
module mbt_dp
	import mbt_pkg::*;
#(
	parameter int CAPACITY  = 16,
	parameter int KEY_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mbt_cmd_t            cmd,
	output mbt_stat_t           stat,
	input  logic [ACT_W-1:0]    in_action,
	input  logic [IN_KEY_W-1:0] in_key,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OUT_W-1:0]    m_tdata
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic [KEY_WIDTH-1:0] mem [CAPACITY];
	logic [KEY_WIDTH-1:0] rd_data_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [ACT_W-1:0]     act_q;
	logic [63:0]          key_ext;

	logic [CW-1:0] fill_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] match_cnt_q;
	logic [CW-1:0] last_idx;
	logic [CW-1:0] fill_nxt;
	logic          cmp_vld_s1;
	logic [AW-1:0] raddr_s1;
	logic          hit_q;
	logic [AW-1:0] hit_idx_q;
	logic          full;
	logic          ok_nxt;

	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [KEY_WIDTH-1:0] wr_data;

	logic          out_valid_q;
	logic          ok_q;
	logic [CNT_W-1:0] matches_q;
	logic [CNT_W-1:0] occ_q;
	logic          empty_q;

	assign key_ext  = 64'(in_key);
	assign last_idx = fill_q - CW'(1);
	assign full     = (fill_q == CW'(CAPACITY));

	always_comb begin
		ok_nxt   = 1'b1;
		fill_nxt = fill_q;
		case (act_q)
			ACT_INSERT: begin
				ok_nxt   = !full;
				fill_nxt = full ? fill_q : fill_q + CW'(1);
			end
			ACT_REMOVE: begin
				ok_nxt   = hit_q;
				fill_nxt = hit_q ? last_idx : fill_q;
			end
			ACT_CLEAR: begin
				fill_nxt = '0;
			end
			default: begin
				fill_nxt = fill_q;
			end
		endcase
	end

	assign rd_en   = cmd.issue | cmd.read_last;
	assign rd_addr = cmd.read_last ? last_idx[AW-1:0] : idx_q[AW-1:0];

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = fill_q[AW-1:0];
		wr_data = key_q;
		if (cmd.commit) begin
			if (act_q == ACT_INSERT && !full) begin
				wr_en = 1'b1;
			end else if (act_q == ACT_REMOVE && hit_q) begin
				// move the last entry into the removed slot
				wr_en   = 1'b1;
				wr_addr = hit_idx_q;
				wr_data = rd_data_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= key_ext[KEY_WIDTH-1:0];
			act_q <= in_action;
		end
		if (cmd.issue) begin
			raddr_s1 <= idx_q[AW-1:0];
		end
		if (cmd.commit) begin
			ok_q      <= ok_nxt;
			matches_q <= CNT_W'(match_cnt_q);
			occ_q     <= CNT_W'(fill_nxt);
			empty_q   <= (fill_nxt == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			idx_q       <= '0;
			match_cnt_q <= '0;
			cmp_vld_s1  <= 1'b0;
			hit_q       <= 1'b0;
			hit_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.issue;
			if (cmd.load) begin
				idx_q       <= '0;
				match_cnt_q <= '0;
				hit_q       <= 1'b0;
			end else begin
				if (cmd.issue) begin
					idx_q <= idx_q + CW'(1);
				end
				if (cmp_vld_s1 && rd_data_q == key_q) begin
					match_cnt_q <= match_cnt_q + CW'(1);
					if (!hit_q) begin
						hit_q     <= 1'b1;
						hit_idx_q <= raddr_s1;
					end
				end
			end
			if (cmd.commit) begin
				fill_q      <= fill_nxt;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.issued_all = (idx_q == fill_q);
	assign stat.cmp_pend   = cmp_vld_s1;
	assign stat.need_last  = (act_q == ACT_REMOVE) && hit_q;
	assign stat.out_free   = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, empty_q, occ_q, matches_q, ok_q};

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(CAPACITY))
		else $error("fill count beyond capacity");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		match_cnt_q <= idx_q)
		else $error("match count exceeds scanned entries");

	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("result not presented after commit");

endmodule

### rtl/multiset_bag_table.sv
// Bounded multiset of keys held in a CAPACITY-entry slot memory. Each item
// (action in s_tuser, key in s_tdata) yields one result: ok, the count of
// stored entries equal to the key before the action, the occupancy after it
// and an empty flag. Items are handled one at a time. The scan of the slot
// memory reads one entry per cycle to count matches and find the first match.
// After the scan the last compare settles, the last entry is fetched when a
// remove has found a match, and the result is committed. A remove then moves
// the last entry into the freed slot. The commit waits while the output
// register still holds an unaccepted result. The next item is taken as soon
// as the commit is done, while the result waits.
module multiset_bag_table
	import mbt_pkg::*;
#(
	parameter int CAPACITY  = 16,
	parameter int KEY_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] key
	input  logic [1:0]  s_tuser,   // [1:0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [0] ok, [5:1] matches_res, [10:6] occupancy,
	                               // [11] empty_res, [15:12] zero
);

	mbt_cmd_t  cmd;
	mbt_stat_t stat;

	mbt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mbt_dp #(
		.CAPACITY  (CAPACITY),
		.KEY_WIDTH (KEY_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_action (s_tuser),
		.in_key    (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
